// File: design/dfr_pkg.sv
// shared types and constants for the delimited frame receiver
// no dependencies; imported by every module of the block except dfr_ram
`default_nettype none

package dfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 1024;

    localparam int FILL_W  = 10;
    localparam int INDEX_W = 10;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int MODE_W  = 2;

    // output tdata: accepted, frame_done, frame_type, fill_count, read_data
    localparam int OUT_W     = 1 + 1 + KIND_W + FILL_W + BYTE_W;
    localparam int OUT_DATA_W = 24;
    localparam int IN_DATA_W  = 24;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam mode_t MODE_BYTE    = 2'd0;
    localparam mode_t MODE_RELEASE = 2'd1;
    localparam mode_t MODE_READ    = 2'd2;

    localparam kind_t KIND_NONE   = 3'd0;
    localparam kind_t KIND_DOLLAR = 3'd1;
    localparam kind_t KIND_HASH   = 3'd2;
    localparam kind_t KIND_BRACE  = 3'd3;
    localparam kind_t KIND_ANGLE  = 3'd4;

    localparam logic [BYTE_W-1:0] CH_ANGLE_OPEN  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_ANGLE_CLOSE = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_DOLLAR      = 8'h24;
    localparam logic [BYTE_W-1:0] CH_HASH        = 8'h23;
    localparam logic [BYTE_W-1:0] CH_BRACE_OPEN  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_BRACE_CLOSE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_BANG        = 8'h21;

    typedef struct packed {
        logic              accepted;
        logic              frame_done;
        kind_t             frame_type;
        logic [FILL_W-1:0] fill_count;
    } dfr_status_t;

endpackage

`default_nettype wire

// File: design/dfr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies; read returns the old contents on a same-address write
`default_nettype none

module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/dfr_ctrl.sv
// frame parser: kind, write position and ready flag, buffer write and read control
// depends on dfr_pkg
`default_nettype none

module dfr_ctrl
    import dfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire mode_t                           mode,
    input  wire logic [BYTE_W-1:0]               rx_byte,
    input  wire logic [INDEX_W-1:0]              read_index,
    output dfr_status_t                          status,
    output logic                                 rd_zero,
    output logic                                 ram_we,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] ram_waddr,
    output logic      [BYTE_W-1:0]               ram_wdata,
    output logic                                 ram_re,
    output logic      [$clog2(BUFFER_DEPTH)-1:0] ram_raddr
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [AW-1:0] pos_reg, pos_next;
    kind_t         kind_reg, kind_next;
    logic          ready_reg, ready_next;
    logic          zpend_reg, zpend_next;
    logic [AW-1:0] zaddr_reg, zaddr_next;
    dfr_status_t   status_reg, status_next;
    logic          rd_zero_reg, rd_zero_next;

    kind_t         kind_new;
    logic [AW-1:0] base;
    logic [AW:0]   pos_inc;
    logic          inc_in;
    logic          ends;
    logic          byte_we;
    logic          read_in;
    logic [AW-1:0] raddr;

    assign raddr   = AW'(read_index);
    assign read_in = 32'(read_index) < BUFFER_DEPTH;

    // frame start and kind for a received byte
    always_comb
    begin
        kind_new = kind_reg;
        base     = pos_reg;
        if (rx_byte == CH_ANGLE_OPEN)
        begin
            kind_new = KIND_ANGLE;
            base     = '0;
        end
        else if (kind_reg == KIND_NONE)
        begin
            case (rx_byte)
                CH_DOLLAR:     kind_new = KIND_DOLLAR;
                CH_HASH:       kind_new = KIND_HASH;
                CH_BRACE_OPEN: kind_new = KIND_BRACE;
                default:       kind_new = KIND_NONE;
            endcase
            base = '0;
        end
        pos_inc = (AW+1)'(base) + (AW+1)'(1);
        inc_in  = 32'(pos_inc) < BUFFER_DEPTH;
        ends    = ((kind_new == KIND_ANGLE) && (rx_byte == CH_ANGLE_CLOSE))
               || (((kind_new == KIND_DOLLAR) || (kind_new == KIND_HASH))
                   && (rx_byte == CH_BANG))
               || ((kind_new == KIND_BRACE) && (rx_byte == CH_BRACE_CLOSE));
    end

    always_comb
    begin
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        ready_next = ready_reg;
        zpend_next = 1'b0;
        zaddr_next = zaddr_reg;
        byte_we    = 1'b0;
        if (accept)
        begin
            unique case (mode)
                MODE_BYTE:
                begin
                    if (!ready_reg)
                    begin
                        byte_we   = 1'b1;
                        kind_next = kind_new;
                        pos_next  = inc_in ? AW'(pos_inc) : '0;
                        if (ends)
                        begin
                            ready_next = 1'b1;
                            zpend_next = inc_in;
                            zaddr_next = AW'(pos_inc);
                        end
                    end
                end
                MODE_RELEASE:
                begin
                    ready_next = 1'b0;
                    kind_next  = KIND_NONE;
                end
                default:
                begin
                end
            endcase
        end

        status_next.accepted   = byte_we;
        status_next.frame_done = ready_next;
        status_next.frame_type = kind_next;
        status_next.fill_count = FILL_W'(pos_next);

        // terminator zero still pending in this cycle is bypassed
        rd_zero_next = (mode != MODE_READ) || !read_in
                    || (zpend_reg && (zaddr_reg == raddr));
    end

    // terminator zero goes in the cycle after the closing byte, when no byte can be stored
    assign ram_we    = byte_we || zpend_reg;
    assign ram_waddr = byte_we ? base : zaddr_reg;
    assign ram_wdata = byte_we ? rx_byte : '0;
    assign ram_re    = accept;
    assign ram_raddr = raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            kind_reg  <= KIND_NONE;
            ready_reg <= 1'b0;
            zpend_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            ready_reg <= ready_next;
            zpend_reg <= zpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zaddr_reg <= zaddr_next;
        if (accept)
        begin
            status_reg  <= status_next;
            rd_zero_reg <= rd_zero_next;
        end
    end

    assign status  = status_reg;
    assign rd_zero = rd_zero_reg;

endmodule

`default_nettype wire

// File: design/dfr_skid.sv
// two-entry output skid buffer, registered ready toward the result stage
// depends on dfr_pkg
`default_nettype none

module dfr_skid
    import dfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [OUT_W-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [OUT_W-1:0] out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0] main_data_reg, main_data_next;
    logic [OUT_W-1:0] skid_data_reg, skid_data_next;
    logic             pop;
    logic             push;

    assign in_ready = !skid_valid_reg;
    assign pop      = main_valid_reg && out_ready;
    assign push     = in_valid && !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_data_next = in_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_data_next  = in_data;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

`default_nettype wire

// File: design/delimited_frame_receiver.sv
// delimited frame receiver top level: parser, frame buffer ram, output skid buffer
// depends on dfr_pkg, dfr_ctrl, dfr_ram, dfr_skid
`default_nettype none

// Takes one item per clock cycle on the slave stream while the skid buffer has room; each item
// gives exactly one result on the master stream, by way of the result register and the skid
// buffer's main register. The parser updates the frame state and the frame buffer write in
// the transfer cycle; the buffer read is registered, and a two-entry skid buffer holds results
// while the master side stalls. The zero after a finished frame is written in the cycle after
// the closing byte, when bytes are dropped anyway. No clearing pass after reset: buffer entries
// read back before they are written hold unknown data.
module delimited_frame_receiver
    import dfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // rx_byte[7:0], read_index[17:8], zero fill
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  wire logic [MODE_W-1:0]     s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // accepted[0], frame_done[1], frame_type[4:2], fill_count[14:5], read_data[22:15], zero fill
    output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic             accept;
    logic             advance;
    logic             res_valid_reg;
    logic             skid_ready;
    dfr_status_t      status;
    logic             rd_zero;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] read_data;
    logic [OUT_W-1:0] res_data;
    logic [OUT_W-1:0] out_data;

    assign advance       = !res_valid_reg || skid_ready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    dfr_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (s_axis_tuser),
        .rx_byte   (s_axis_tdata[7:0]),
        .read_index(s_axis_tdata[17:8]),
        .status    (status),
        .rd_zero   (rd_zero),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    dfr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(BUFFER_DEPTH)
    ) u_buf (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s_axis_tvalid;
        end
    end

    assign read_data = rd_zero ? '0 : ram_rdata;
    assign res_data  = {read_data, status.fill_count, status.frame_type,
                        status.frame_done, status.accepted};

    dfr_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid_reg),
        .in_ready (skid_ready),
        .in_data  (res_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (out_data)
    );

    assign m_axis_tdata = OUT_DATA_W'(out_data);

endmodule

`default_nettype wire

// File: tb/testbench.sv
// stream-level testbench for delimited_frame_receiver: random and directed frames checked
// against a behavioral frame parser kept in a small scoreboard class
// depends on dfr_pkg and the design sources
`timescale 1ns / 100ps

module testbench;
    import dfr_pkg::*;

    localparam mode_t MODE_UNUSED = 2'd3;
    localparam int    CYCLE_LIMIT = 400000;
    localparam int    ITEM_TARGET = 1700;

    typedef struct packed {
        logic              accepted;
        logic              frame_done;
        kind_t             frame_type;
        logic [FILL_W-1:0] fill_count;
        logic [BYTE_W-1:0] read_data;
    } frame_result_t;

    class frame_scoreboard;
        logic [BYTE_W-1:0] mem [BUFFER_DEPTH_DEF];
        bit                stored [BUFFER_DEPTH_DEF];
        int unsigned       max_stored;
        int unsigned       wpos;
        kind_t             kind;
        bit                ready;
        frame_result_t     pending [$];
        int                errors;

        function new();
            wpos       = 0;
            kind       = KIND_NONE;
            ready      = 1'b0;
            max_stored = 0;
            errors     = 0;
            foreach (stored[i])
                stored[i] = 1'b0;
        endfunction

        function void write_mem(int unsigned pos, logic [BYTE_W-1:0] b);
            mem[pos]    = b;
            stored[pos] = 1'b1;
            if (pos > max_stored)
                max_stored = pos;
        endfunction

        function bit closes(logic [BYTE_W-1:0] b);
            return (kind == KIND_ANGLE && b == CH_ANGLE_CLOSE) ||
                   ((kind == KIND_DOLLAR || kind == KIND_HASH) && b == CH_BANG) ||
                   (kind == KIND_BRACE && b == CH_BRACE_CLOSE);
        endfunction

        function void note_item(mode_t m, logic [BYTE_W-1:0] b, logic [INDEX_W-1:0] ri);
            frame_result_t want;
            int unsigned   next;
            want = '0;
            case (m)
                MODE_BYTE:
                    if (!ready)
                    begin
                        if (b == CH_ANGLE_OPEN)
                        begin
                            kind = KIND_ANGLE;
                            wpos = 0;
                        end
                        else if (kind == KIND_NONE)
                        begin
                            if (b == CH_DOLLAR)
                                kind = KIND_DOLLAR;
                            else if (b == CH_HASH)
                                kind = KIND_HASH;
                            else if (b == CH_BRACE_OPEN)
                                kind = KIND_BRACE;
                            wpos = 0;
                        end
                        write_mem(wpos, b);
                        next = wpos + 1;
                        if (closes(b))
                        begin
                            if (next < BUFFER_DEPTH_DEF)
                                write_mem(next, '0);
                            ready = 1'b1;
                        end
                        wpos = (next >= BUFFER_DEPTH_DEF) ? 0 : next;
                        want.accepted = 1'b1;
                    end
                MODE_RELEASE:
                begin
                    ready = 1'b0;
                    kind  = KIND_NONE;
                end
                MODE_READ:
                    want.read_data = mem[ri];
                default: ;
            endcase
            want.frame_done = ready;
            want.frame_type = kind;
            want.fill_count = wpos[FILL_W-1:0];
            pending.push_back(want);
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_status(logic [OUT_DATA_W-1:0] d);
            frame_result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", d));
                return;
            end
            want = pending.pop_front();
            if (d[0] !== want.accepted)
                report($sformatf("accepted %b, want %b", d[0], want.accepted));
            if (d[1] !== want.frame_done)
                report($sformatf("frame_done %b, want %b", d[1], want.frame_done));
            if (d[4:2] !== want.frame_type)
                report($sformatf("frame_type %0d, want %0d", d[4:2], want.frame_type));
            if (d[14:5] !== want.fill_count)
                report($sformatf("fill_count %0d, want %0d", d[14:5], want.fill_count));
            if (d[22:15] !== want.read_data)
                report($sformatf("read_data %h, want %h", d[22:15], want.read_data));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [MODE_W-1:0]     s_user = '0;
    logic                  m_ready = 1'b0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    frame_scoreboard sb = new();
    int  items_done = 0;
    int  send_idle_pct = 20;
    int  recv_idle_pct = 76;
    logic rx_hold = 1'b0;
    int  cycles = 0;

    delimited_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(mode_t m, logic [BYTE_W-1:0] b, logic [INDEX_W-1:0] ri);
        if (items_done < 600)
        begin
            send_idle_pct  = 20;
            recv_idle_pct <= 76;
        end
        else if (items_done < 1200)
        begin
            send_idle_pct  = 76;
            recv_idle_pct <= 20;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_idle_pct <= 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(IN_DATA_W - INDEX_W - BYTE_W){1'b0}}, ri, b};
        s_user  <= m;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (m == MODE_RELEASE || m == MODE_READ || (m == MODE_BYTE && !sb.ready))
            items_done++;
        sb.note_item(m, b, ri);
    endtask

    task automatic push_byte(logic [BYTE_W-1:0] b);
        send_item(MODE_BYTE, b, INDEX_W'($urandom_range(1023)));
    endtask

    task automatic push_read();
        int unsigned r;
        r = $urandom_range(BUFFER_DEPTH_DEF - 1);
        if (!sb.stored[r])
            r = $urandom_range(sb.max_stored);
        send_item(MODE_READ, BYTE_W'($urandom_range(255)), INDEX_W'(r));
    endtask

    task automatic push_release();
        send_item(MODE_RELEASE, BYTE_W'($urandom_range(255)), INDEX_W'($urandom_range(1023)));
    endtask

    function automatic logic [BYTE_W-1:0] closer_for(logic [BYTE_W-1:0] opener);
        case (opener)
            CH_ANGLE_OPEN: return CH_ANGLE_CLOSE;
            CH_BRACE_OPEN: return CH_BRACE_CLOSE;
            default:       return CH_BANG;
        endcase
    endfunction

    // receiving side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_ready)
                sb.check_status(m_axis_tdata);
            m_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall so the skid buffer fills and input backs up
    initial
    begin
        wait (items_done >= 1300);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] opener;
        int                sel;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused mode, idle release, kind-0 bytes, simple frames, drops, restarts
        send_item(MODE_UNUSED, 8'hFF, 10'h3FF);
        push_release();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_DOLLAR);
        push_byte(8'h61);
        push_byte(CH_BANG);
        push_byte(8'h78);
        push_byte(CH_ANGLE_OPEN);
        send_item(MODE_READ, 8'h00, 10'd0);
        send_item(MODE_READ, 8'hFF, 10'd2);
        send_item(MODE_READ, 8'h00, 10'd3);
        push_release();
        push_byte(CH_HASH);
        push_byte(CH_BANG);
        push_release();
        push_byte(CH_BRACE_OPEN);
        push_byte(CH_BANG);
        push_byte(CH_ANGLE_CLOSE);
        push_byte(CH_BRACE_CLOSE);
        push_release();
        push_byte(CH_ANGLE_OPEN);
        push_byte(CH_BANG);
        push_byte(CH_ANGLE_OPEN);
        push_byte(CH_ANGLE_CLOSE);
        push_release();

        // frame that fills the whole buffer: the closing byte lands on the last entry, so no terminator is stored
        push_byte(CH_ANGLE_OPEN);
        repeat (BUFFER_DEPTH_DEF - 2)
        begin
            do
                b = BYTE_W'($urandom_range(255));
            while (b == CH_ANGLE_OPEN || b == CH_ANGLE_CLOSE);
            push_byte(b);
        end
        push_byte(CH_ANGLE_CLOSE);
        repeat (4) push_read();
        push_release();

        while (items_done < ITEM_TARGET)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                case ($urandom_range(3))
                    0:       opener = CH_ANGLE_OPEN;
                    1:       opener = CH_DOLLAR;
                    2:       opener = CH_HASH;
                    default: opener = CH_BRACE_OPEN;
                endcase
                push_byte(opener);
                repeat ($urandom_range(12))
                    push_byte(BYTE_W'($urandom_range(255)));
                push_byte(closer_for(opener));
                repeat ($urandom_range(3))
                    push_read();
                if ($urandom_range(9) == 0)
                    push_byte(BYTE_W'($urandom_range(255)));
                if ($urandom_range(9) != 0)
                    push_release();
            end
            else if (sel < 85)
                repeat ($urandom_range(1, 4))
                    push_byte(BYTE_W'($urandom_range(255)));
            else if (sel < 95)
                push_read();
            else if (sel < 98)
                push_release();
            else
                send_item(MODE_UNUSED, BYTE_W'($urandom_range(255)),
                          INDEX_W'($urandom_range(1023)));
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
